// ===== sv/sps_pkg.sv =====
// Shared types, syntax step codes and helper functions for the SPS dimension parser.
// No dependencies.
package sps_pkg;

  localparam int PREFIX_LIMIT_DEF = 31;
  localparam int STEP_W = 6;

  localparam logic [STEP_W-1:0] S_PROFILE       = 6'd0;
  localparam logic [STEP_W-1:0] S_CONSTRAINT    = 6'd1;
  localparam logic [STEP_W-1:0] S_LEVEL         = 6'd2;
  localparam logic [STEP_W-1:0] S_SPS_ID        = 6'd3;
  localparam logic [STEP_W-1:0] S_CHROMA        = 6'd4;
  localparam logic [STEP_W-1:0] S_SEP_PLANE     = 6'd5;
  localparam logic [STEP_W-1:0] S_DEPTH_LUMA    = 6'd6;
  localparam logic [STEP_W-1:0] S_DEPTH_CHROMA  = 6'd7;
  localparam logic [STEP_W-1:0] S_BYPASS        = 6'd8;
  localparam logic [STEP_W-1:0] S_SCALE_PRESENT = 6'd9;
  localparam logic [STEP_W-1:0] S_LIST_FLAG     = 6'd10;
  localparam logic [STEP_W-1:0] S_DELTA         = 6'd11;
  localparam logic [STEP_W-1:0] S_LOG2_FN       = 6'd12;
  localparam logic [STEP_W-1:0] S_POC_TYPE      = 6'd13;
  localparam logic [STEP_W-1:0] S_POC_LSB       = 6'd14;
  localparam logic [STEP_W-1:0] S_ZERO_FLAG     = 6'd15;
  localparam logic [STEP_W-1:0] S_OFS_NONREF    = 6'd16;
  localparam logic [STEP_W-1:0] S_OFS_T2B       = 6'd17;
  localparam logic [STEP_W-1:0] S_CYCLE_LEN     = 6'd18;
  localparam logic [STEP_W-1:0] S_CYCLE_OFS     = 6'd19;
  localparam logic [STEP_W-1:0] S_MAX_REF       = 6'd20;
  localparam logic [STEP_W-1:0] S_GAPS          = 6'd21;
  localparam logic [STEP_W-1:0] S_WIDTH         = 6'd22;
  localparam logic [STEP_W-1:0] S_HEIGHT        = 6'd23;
  localparam logic [STEP_W-1:0] S_FRAME_ONLY    = 6'd24;
  localparam logic [STEP_W-1:0] S_MBAFF         = 6'd25;
  localparam logic [STEP_W-1:0] S_DIRECT8       = 6'd26;
  localparam logic [STEP_W-1:0] S_CROP_FLAG     = 6'd27;
  localparam logic [STEP_W-1:0] S_CROP0         = 6'd28;
  localparam logic [STEP_W-1:0] S_CROP1         = 6'd29;
  localparam logic [STEP_W-1:0] S_CROP2         = 6'd30;
  localparam logic [STEP_W-1:0] S_CROP3         = 6'd31;
  localparam logic [STEP_W-1:0] S_DONE          = 6'd32;

  localparam logic CFG_MAX_WIDTH  = 1'b0;
  localparam logic CFG_MAX_HEIGHT = 1'b1;

  typedef struct packed {
    logic        parse_valid;
    logic        parse_done;
    logic [1:0]  chroma;
    logic        chroma_big;
    logic        frame_only;
    logic [31:0] width_units;
    logic [31:0] height_units;
    logic [31:0] crop0;
    logic [31:0] crop1;
    logic [31:0] crop2;
    logic [31:0] crop3;
  } sps_fields_t;

  typedef struct packed {
    logic        ok;
    logic [13:0] width;
    logic [13:0] height;
  } sps_dims_t;

  function automatic logic [3:0] step_bits(input logic [STEP_W-1:0] s);
    logic [3:0] n;
    n = 4'd0;
    unique case (s)
      S_PROFILE, S_CONSTRAINT, S_LEVEL: n = 4'd8;
      S_SEP_PLANE, S_BYPASS, S_SCALE_PRESENT, S_LIST_FLAG, S_ZERO_FLAG, S_GAPS,
      S_FRAME_ONLY, S_MBAFF, S_DIRECT8, S_CROP_FLAG: n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
           p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 ||
           p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134;
  endfunction

endpackage

// ===== sv/sps_ifaces.sv =====
// Valid/ready channel interfaces for NAL bytes in and picture dimensions out.
// No dependencies.
interface sps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] nal_byte;
  logic       last_byte;
  modport source (output valid, nal_byte, last_byte, input ready);
  modport sink (input valid, nal_byte, last_byte, output ready);
endinterface

interface sps_dims_if;
  logic        valid;
  logic        ready;
  logic        dims_ok;
  logic [13:0] frame_width;
  logic [13:0] frame_height;
  modport source (output valid, dims_ok, frame_width, frame_height, input ready);
  modport sink (input valid, dims_ok, frame_width, frame_height, output ready);
endinterface

// ===== sv/sps_bit_parser.sv =====
// Exp-Golomb syntax machine that consumes one SPS payload bit per cycle while bit_vld is high.
// Depends on sps_pkg.
module sps_bit_parser #(
  parameter int PREFIX_LIMIT = sps_pkg::PREFIX_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic                bit_vld,
  input  logic                bit_in,
  output sps_pkg::sps_fields_t fields
);

  logic [5:0]  step_r, step_nxt;
  logic [5:0]  bit_cnt_r, bit_cnt_nxt;
  logic [5:0]  pz_r, pz_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        suffix_r, suffix_nxt;
  logic [7:0]  profile_r, profile_nxt;
  logic [1:0]  chroma_r, chroma_nxt;
  logic        chroma_big_r, chroma_big_nxt;
  logic        fo_r, fo_nxt;
  logic [31:0] wu_r, wu_nxt, hu_r, hu_nxt;
  logic [31:0] crop_r [4];
  logic [31:0] crop_nxt [4];
  logic [3:0]  list_r, list_nxt;
  logic [6:0]  entry_r, entry_nxt;
  logic [7:0]  last_scale_r, last_scale_nxt;
  logic [31:0] ctot_r, ctot_nxt, cidx_r, cidx_nxt;
  logic        valid_r, valid_nxt, done_r, done_nxt;

  logic        feed, elem;
  logic [3:0]  n;
  logic [31:0] acc_sh, v;
  logic [5:0]  cnt_inc, pz_inc;
  logic [3:0]  list_inc;
  logic [5:0]  list_step;
  logic [6:0]  entry_inc;
  logic [7:0]  nscale;

  always_comb begin
    step_nxt = step_r;
    bit_cnt_nxt = bit_cnt_r;
    pz_nxt = pz_r;
    acc_nxt = acc_r;
    suffix_nxt = suffix_r;
    profile_nxt = profile_r;
    chroma_nxt = chroma_r;
    chroma_big_nxt = chroma_big_r;
    fo_nxt = fo_r;
    wu_nxt = wu_r;
    hu_nxt = hu_r;
    crop_nxt = crop_r;
    list_nxt = list_r;
    entry_nxt = entry_r;
    last_scale_nxt = last_scale_r;
    ctot_nxt = ctot_r;
    cidx_nxt = cidx_r;
    valid_nxt = valid_r;
    done_nxt = done_r;
    feed = bit_vld && valid_r && !done_r;
    n = sps_pkg::step_bits(step_r);
    acc_sh = {acc_r[30:0], bit_in};
    cnt_inc = bit_cnt_r + 6'd1;
    pz_inc = pz_r + 6'd1;
    elem = 1'b0;
    v = 32'd0;
    list_inc = list_r + 4'd1;
    list_step = (list_inc < ((!chroma_big_r && chroma_r == 2'd3) ? 4'd12 : 4'd8)) ?
                sps_pkg::S_LIST_FLAG : sps_pkg::S_LOG2_FN;
    entry_inc = entry_r + 7'd1;
    nscale = 8'd0;
    if (feed) begin
      if (n != 4'd0) begin
        acc_nxt = acc_sh;
        bit_cnt_nxt = cnt_inc;
        if (cnt_inc >= {2'b00, n}) begin
          elem = 1'b1;
          v = acc_sh;
        end
      end else if (!suffix_r) begin
        if (!bit_in) begin
          pz_nxt = pz_inc;
          if (pz_inc > 6'(PREFIX_LIMIT)) valid_nxt = 1'b0;
        end else if (pz_r == 6'd0) begin
          elem = 1'b1;
        end else begin
          suffix_nxt = 1'b1;
          bit_cnt_nxt = 6'd0;
          acc_nxt = 32'd0;
        end
      end else begin
        acc_nxt = acc_sh;
        bit_cnt_nxt = cnt_inc;
        if (cnt_inc >= pz_r) begin
          elem = 1'b1;
          v = ((32'd1 << pz_r[4:0]) - 32'd1) + acc_sh;
        end
      end
    end
    if (elem) begin
      unique case (step_r)
        sps_pkg::S_PROFILE: begin
          profile_nxt = v[7:0];
          step_nxt = sps_pkg::S_CONSTRAINT;
        end
        sps_pkg::S_CONSTRAINT: step_nxt = sps_pkg::S_LEVEL;
        sps_pkg::S_LEVEL: step_nxt = sps_pkg::S_SPS_ID;
        sps_pkg::S_SPS_ID:
          step_nxt = sps_pkg::high_profile(profile_r) ? sps_pkg::S_CHROMA : sps_pkg::S_LOG2_FN;
        sps_pkg::S_CHROMA: begin
          chroma_nxt = v[1:0];
          chroma_big_nxt = |v[31:2];
          step_nxt = (v == 32'd3) ? sps_pkg::S_SEP_PLANE : sps_pkg::S_DEPTH_LUMA;
        end
        sps_pkg::S_SEP_PLANE: step_nxt = sps_pkg::S_DEPTH_LUMA;
        sps_pkg::S_DEPTH_LUMA: step_nxt = sps_pkg::S_DEPTH_CHROMA;
        sps_pkg::S_DEPTH_CHROMA: step_nxt = sps_pkg::S_BYPASS;
        sps_pkg::S_BYPASS: step_nxt = sps_pkg::S_SCALE_PRESENT;
        sps_pkg::S_SCALE_PRESENT: begin
          list_nxt = 4'd0;
          step_nxt = v[0] ? sps_pkg::S_LIST_FLAG : sps_pkg::S_LOG2_FN;
        end
        sps_pkg::S_LIST_FLAG: begin
          if (v[0]) begin
            entry_nxt = 7'd0;
            last_scale_nxt = 8'd8;
            step_nxt = sps_pkg::S_DELTA;
          end else begin
            list_nxt = list_inc;
            step_nxt = list_step;
          end
        end
        sps_pkg::S_DELTA: begin
          if (v[0]) nscale = last_scale_r + v[8:1] + 8'd1;
          else nscale = last_scale_r - v[8:1];
          if (nscale != 8'd0) last_scale_nxt = nscale;
          entry_nxt = entry_inc;
          if (entry_inc >= ((list_r < 4'd6) ? 7'd16 : 7'd64) || nscale == 8'd0) begin
            list_nxt = list_inc;
            step_nxt = list_step;
          end
        end
        sps_pkg::S_LOG2_FN: step_nxt = sps_pkg::S_POC_TYPE;
        sps_pkg::S_POC_TYPE:
          step_nxt = (v == 32'd0) ? sps_pkg::S_POC_LSB :
                     ((v == 32'd1) ? sps_pkg::S_ZERO_FLAG : sps_pkg::S_MAX_REF);
        sps_pkg::S_POC_LSB: step_nxt = sps_pkg::S_MAX_REF;
        sps_pkg::S_ZERO_FLAG: step_nxt = sps_pkg::S_OFS_NONREF;
        sps_pkg::S_OFS_NONREF: step_nxt = sps_pkg::S_OFS_T2B;
        sps_pkg::S_OFS_T2B: step_nxt = sps_pkg::S_CYCLE_LEN;
        sps_pkg::S_CYCLE_LEN: begin
          ctot_nxt = v;
          cidx_nxt = 32'd0;
          step_nxt = (v == 32'd0) ? sps_pkg::S_MAX_REF : sps_pkg::S_CYCLE_OFS;
        end
        sps_pkg::S_CYCLE_OFS: begin
          cidx_nxt = cidx_r + 32'd1;
          if (cidx_r + 32'd1 >= ctot_r) step_nxt = sps_pkg::S_MAX_REF;
        end
        sps_pkg::S_MAX_REF: step_nxt = sps_pkg::S_GAPS;
        sps_pkg::S_GAPS: step_nxt = sps_pkg::S_WIDTH;
        sps_pkg::S_WIDTH: begin
          wu_nxt = v;
          step_nxt = sps_pkg::S_HEIGHT;
        end
        sps_pkg::S_HEIGHT: begin
          hu_nxt = v;
          step_nxt = sps_pkg::S_FRAME_ONLY;
        end
        sps_pkg::S_FRAME_ONLY: begin
          fo_nxt = v[0];
          step_nxt = v[0] ? sps_pkg::S_DIRECT8 : sps_pkg::S_MBAFF;
        end
        sps_pkg::S_MBAFF: step_nxt = sps_pkg::S_DIRECT8;
        sps_pkg::S_DIRECT8: step_nxt = sps_pkg::S_CROP_FLAG;
        sps_pkg::S_CROP_FLAG: begin
          if (v[0]) begin
            step_nxt = sps_pkg::S_CROP0;
          end else begin
            step_nxt = sps_pkg::S_DONE;
            done_nxt = 1'b1;
          end
        end
        sps_pkg::S_CROP0, sps_pkg::S_CROP1, sps_pkg::S_CROP2, sps_pkg::S_CROP3: begin
          crop_nxt[step_r[1:0]] = v;
          step_nxt = step_r + 6'd1;
          if (step_r == sps_pkg::S_CROP3) done_nxt = 1'b1;
        end
        default: begin
          done_nxt = 1'b1;
          step_nxt = sps_pkg::S_DONE;
        end
      endcase
      bit_cnt_nxt = 6'd0;
      pz_nxt = 6'd0;
      acc_nxt = 32'd0;
      suffix_nxt = 1'b0;
    end
    if (clear) begin
      step_nxt = sps_pkg::S_PROFILE;
      bit_cnt_nxt = 6'd0;
      pz_nxt = 6'd0;
      acc_nxt = 32'd0;
      suffix_nxt = 1'b0;
      profile_nxt = 8'd0;
      chroma_nxt = 2'd1;
      chroma_big_nxt = 1'b0;
      fo_nxt = 1'b0;
      wu_nxt = 32'd0;
      hu_nxt = 32'd0;
      crop_nxt = '{default: 32'd0};
      list_nxt = 4'd0;
      entry_nxt = 7'd0;
      last_scale_nxt = 8'd8;
      ctot_nxt = 32'd0;
      cidx_nxt = 32'd0;
      valid_nxt = 1'b1;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sps_pkg::S_PROFILE;
      bit_cnt_r <= 6'd0;
      pz_r <= 6'd0;
      acc_r <= 32'd0;
      suffix_r <= 1'b0;
      profile_r <= 8'd0;
      chroma_r <= 2'd1;
      chroma_big_r <= 1'b0;
      fo_r <= 1'b0;
      wu_r <= 32'd0;
      hu_r <= 32'd0;
      crop_r <= '{default: 32'd0};
      list_r <= 4'd0;
      entry_r <= 7'd0;
      last_scale_r <= 8'd8;
      ctot_r <= 32'd0;
      cidx_r <= 32'd0;
      valid_r <= 1'b1;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      pz_r <= pz_nxt;
      acc_r <= acc_nxt;
      suffix_r <= suffix_nxt;
      profile_r <= profile_nxt;
      chroma_r <= chroma_nxt;
      chroma_big_r <= chroma_big_nxt;
      fo_r <= fo_nxt;
      wu_r <= wu_nxt;
      hu_r <= hu_nxt;
      crop_r <= crop_nxt;
      list_r <= list_nxt;
      entry_r <= entry_nxt;
      last_scale_r <= last_scale_nxt;
      ctot_r <= ctot_nxt;
      cidx_r <= cidx_nxt;
      valid_r <= valid_nxt;
      done_r <= done_nxt;
    end
  end

  always_comb begin
    fields.parse_valid = valid_r;
    fields.parse_done = done_r;
    fields.chroma = chroma_r;
    fields.chroma_big = chroma_big_r;
    fields.frame_only = fo_r;
    fields.width_units = wu_r;
    fields.height_units = hu_r;
    fields.crop0 = crop_r[0];
    fields.crop1 = crop_r[1];
    fields.crop2 = crop_r[2];
    fields.crop3 = crop_r[3];
  end

endmodule

// ===== sv/sps_dims_calc.sv =====
// Two-stage cropped size computation and limit check from the parsed SPS fields.
// Depends on sps_pkg.
module sps_dims_calc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  sps_pkg::sps_fields_t fields,
  input  logic [13:0]          max_width,
  input  logic [13:0]          max_height,
  output logic                 res_vld,
  output sps_pkg::sps_dims_t   res
);

  logic        s1_vld_r, bad_r;
  logic [31:0] pw_base_r, cx_r, ph_base_r, cy_r;
  logic        ux2, uy_c2;
  logic [31:0] sx, sy, pw, ph;
  logic        ok;

  always_comb begin
    ux2 = fields.chroma == 2'd1 || fields.chroma == 2'd2;
    uy_c2 = fields.chroma == 2'd1;
    sx = fields.crop0 + fields.crop1;
    sy = fields.crop2 + fields.crop3;
    pw = pw_base_r - cx_r;
    ph = ph_base_r - cy_r;
    ok = !bad_r && pw != 32'd0 && ph != 32'd0 &&
         pw <= {18'd0, max_width} && ph <= {18'd0, max_height};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      s1_vld_r <= start;
      res_vld <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bad_r <= !fields.parse_valid || !fields.parse_done || fields.chroma_big;
      pw_base_r <= {fields.width_units[27:0] + 28'd1, 4'd0};
      ph_base_r <= fields.frame_only ? {fields.height_units[27:0] + 28'd1, 4'd0} :
                                       {fields.height_units[26:0] + 27'd1, 5'd0};
      cx_r <= ux2 ? {sx[30:0], 1'b0} : sx;
      cy_r <= sy << ({1'b0, uy_c2} + {1'b0, !fields.frame_only});
    end
    if (s1_vld_r) begin
      res.ok <= ok;
      res.width <= ok ? pw[13:0] : 14'd0;
      res.height <= ok ? ph[13:0] : 14'd0;
    end
  end

endmodule

// ===== sv/h264_sps_dimension_parser.sv =====
// H.264 SPS dimension parser top level: byte intake, emulation-prevention removal,
// bit serializer, limit registers and output register. Depends on sps_pkg,
// sps_ifaces, sps_bit_parser and sps_dims_calc.
// A payload byte is accepted and then shifted MSB first through the syntax machine,
// which holds off the next byte; header and emulation-prevention bytes are only accepted.
// A last byte's word is offered after ST_START, both sps_dims_calc stages and the output register.
// Synchronous active-low reset clears the parser; limits reset to 4096 x 2304.
module h264_sps_dimension_parser #(
  parameter int PREFIX_LIMIT = sps_pkg::PREFIX_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sps_byte_if.sink    in_byte,
  sps_dims_if.source  out_dims,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [13:0] cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BITS  = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_CALC  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  shift_r;
  logic [2:0]  bit_cnt_r;
  logic        last_r, hdr_r;
  logic [1:0]  zrun_r;
  logic [13:0] max_w_r, max_h_r;
  logic        out_vld_r;
  sps_pkg::sps_dims_t out_r;
  logic        acc, feed, start, clear, res_vld;
  sps_pkg::sps_fields_t fields;
  sps_pkg::sps_dims_t   res;

  assign acc = in_byte.valid && in_byte.ready;
  assign in_byte.ready = state_r == ST_IDLE;
  assign feed = hdr_r && !(zrun_r == 2'd2 && in_byte.nal_byte == 8'd3);
  assign start = state_r == ST_START && (!out_vld_r || out_dims.ready);
  assign clear = start;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (feed) state_nxt = ST_BITS;
          else if (in_byte.last_byte) state_nxt = ST_START;
        end
      end
      ST_BITS: begin
        if (bit_cnt_r == 3'd7) state_nxt = last_r ? ST_START : ST_IDLE;
      end
      ST_START: begin
        if (start) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (res_vld) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bit_cnt_r <= 3'd0;
      hdr_r <= 1'b0;
      zrun_r <= 2'd0;
      max_w_r <= 14'd4096;
      max_h_r <= 14'd2304;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        bit_cnt_r <= 3'd0;
        if (!hdr_r) begin
          hdr_r <= 1'b1;
        end else if (!feed) begin
          zrun_r <= 2'd0;
        end else if (in_byte.nal_byte == 8'd0) begin
          if (zrun_r != 2'd2) zrun_r <= zrun_r + 2'd1;
        end else begin
          zrun_r <= 2'd0;
        end
      end else if (state_r == ST_BITS) begin
        bit_cnt_r <= bit_cnt_r + 3'd1;
      end
      if (clear) begin
        hdr_r <= 1'b0;
        zrun_r <= 2'd0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          sps_pkg::CFG_MAX_WIDTH: max_w_r <= cfg_data;
          sps_pkg::CFG_MAX_HEIGHT: max_h_r <= cfg_data;
          default: ;
        endcase
      end
      if (res_vld) out_vld_r <= 1'b1;
      else if (out_dims.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      shift_r <= in_byte.nal_byte;
      last_r <= in_byte.last_byte;
    end else if (state_r == ST_BITS) begin
      shift_r <= {shift_r[6:0], 1'b0};
    end
    if (res_vld) out_r <= res;
  end

  sps_bit_parser #(.PREFIX_LIMIT(PREFIX_LIMIT)) u_bits (
    .clk(clk),
    .rst_n(rst_n),
    .clear(clear),
    .bit_vld(state_r == ST_BITS),
    .bit_in(shift_r[7]),
    .fields(fields)
  );

  sps_dims_calc u_dims (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .fields(fields),
    .max_width(max_w_r),
    .max_height(max_h_r),
    .res_vld(res_vld),
    .res(res)
  );

  assign out_dims.valid = out_vld_r;
  assign out_dims.dims_ok = out_r.ok;
  assign out_dims.frame_width = out_r.width;
  assign out_dims.frame_height = out_r.height;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for h264_sps_dimension_parser: sends SPS NAL units
// byte by byte and checks each dimension word against an internal predictor.
// Depends on sps_pkg, sps_ifaces and the parser RTL.
`timescale 1ns / 100ps

module tb;
  import sps_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [13:0] width;
    logic [13:0] height;
  } dims_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [13:0] cfg_data;

  sps_byte_if in_ch();
  sps_dims_if out_ch();

  h264_sps_dimension_parser u_top (
    .clk(clk), .rst_n(rst_n), .in_byte(in_ch.sink), .out_dims(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Predictor state.
  int unsigned lim_w, lim_h;
  bit hdr_seen;
  int unsigned zrun, step, nbits, pzeros;
  longint unsigned acc;
  bit suffix;
  int unsigned profile, chroma, frame_only, wunits, hunits;
  int unsigned crop[4];
  int unsigned list_i, entry_i, last_sc, next_sc, cyc_total, cyc_i;
  bit pvalid, pdone;

  dims_word_t expected_dims[$];
  int mismatches;
  int send_idle_pct, recv_idle_pct;

  // Bit-stream builder used to assemble SPS payloads.
  bit sps_bits[$];
  byte unsigned nal[$];

  function automatic void clear_parser();
    hdr_seen = 0; zrun = 0; step = S_PROFILE; nbits = 0; pzeros = 0; acc = 0;
    suffix = 0; profile = 0; chroma = 1; frame_only = 0; wunits = 0; hunits = 0;
    crop = '{0, 0, 0, 0}; list_i = 0; entry_i = 0; last_sc = 8; next_sc = 8;
    cyc_total = 0; cyc_i = 0; pvalid = 1; pdone = 0;
  endfunction

  function automatic int unsigned fixed_len(int unsigned s);
    case (s)
      S_PROFILE, S_CONSTRAINT, S_LEVEL: return 8;
      S_SEP_PLANE, S_BYPASS, S_SCALE_PRESENT, S_LIST_FLAG, S_ZERO_FLAG, S_GAPS,
      S_FRAME_ONLY, S_MBAFF, S_DIRECT8, S_CROP_FLAG: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic bit is_high(int unsigned p);
    return p == 100 || p == 110 || p == 122 || p == 244 || p == 44 || p == 83 ||
           p == 86 || p == 118 || p == 128 || p == 138 || p == 139 || p == 134;
  endfunction

  function automatic void advance_list();
    int unsigned cnt;
    cnt = (chroma == 3) ? 12 : 8;
    list_i = (list_i + 1) & 15;
    step = (list_i < cnt) ? S_LIST_FLAG : S_LOG2_FN;
  endfunction

  function automatic void finish_element(int unsigned v);
    int unsigned sz;
    case (step)
      S_PROFILE: begin profile = v & 255; step = S_CONSTRAINT; end
      S_CONSTRAINT: step = S_LEVEL;
      S_LEVEL: step = S_SPS_ID;
      S_SPS_ID: step = is_high(profile) ? S_CHROMA : S_LOG2_FN;
      S_CHROMA: begin chroma = v; step = (v == 3) ? S_SEP_PLANE : S_DEPTH_LUMA; end
      S_SEP_PLANE: step = S_DEPTH_LUMA;
      S_DEPTH_LUMA: step = S_DEPTH_CHROMA;
      S_DEPTH_CHROMA: step = S_BYPASS;
      S_BYPASS: step = S_SCALE_PRESENT;
      S_SCALE_PRESENT: begin list_i = 0; step = v ? S_LIST_FLAG : S_LOG2_FN; end
      S_LIST_FLAG: begin
        if (v) begin
          entry_i = 0; last_sc = 8; next_sc = 8; step = S_DELTA;
        end else begin
          advance_list();
        end
      end
      S_DELTA: begin
        if (v & 1) next_sc = (last_sc + (v / 2 + 1)) & 255;
        else next_sc = (last_sc - v / 2) & 255;
        if (next_sc != 0) last_sc = next_sc;
        entry_i = (entry_i + 1) & 127;
        sz = (list_i < 6) ? 16 : 64;
        if (entry_i >= sz || next_sc == 0) advance_list();
      end
      S_LOG2_FN: step = S_POC_TYPE;
      S_POC_TYPE: step = (v == 0) ? S_POC_LSB : ((v == 1) ? S_ZERO_FLAG : S_MAX_REF);
      S_POC_LSB: step = S_MAX_REF;
      S_ZERO_FLAG: step = S_OFS_NONREF;
      S_OFS_NONREF: step = S_OFS_T2B;
      S_OFS_T2B: step = S_CYCLE_LEN;
      S_CYCLE_LEN: begin
        cyc_total = v; cyc_i = 0; step = (v == 0) ? S_MAX_REF : S_CYCLE_OFS;
      end
      S_CYCLE_OFS: begin
        cyc_i++;
        if (cyc_i >= cyc_total) step = S_MAX_REF;
      end
      S_MAX_REF: step = S_GAPS;
      S_GAPS: step = S_WIDTH;
      S_WIDTH: begin wunits = v; step = S_HEIGHT; end
      S_HEIGHT: begin hunits = v; step = S_FRAME_ONLY; end
      S_FRAME_ONLY: begin
        frame_only = v & 1; step = frame_only ? S_DIRECT8 : S_MBAFF;
      end
      S_MBAFF: step = S_DIRECT8;
      S_DIRECT8: step = S_CROP_FLAG;
      S_CROP_FLAG: begin
        if (v) step = S_CROP0;
        else begin step = S_DONE; pdone = 1; end
      end
      S_CROP0, S_CROP1, S_CROP2, S_CROP3: begin
        crop[(step - S_CROP0) & 3] = v;
        step++;
        if (step == S_DONE) pdone = 1;
      end
      default: begin pdone = 1; step = S_DONE; end
    endcase
    nbits = 0; pzeros = 0; acc = 0; suffix = 0;
  endfunction

  function automatic void take_bit(bit b);
    int unsigned n;
    if (!pvalid || pdone) return;
    n = fixed_len(step);
    if (n != 0) begin
      acc = ((acc << 1) | b) & 64'h1_FFFF_FFFF;
      nbits++;
      if (nbits >= n) finish_element(acc[31:0]);
      return;
    end
    if (!suffix) begin
      if (b == 0) begin
        pzeros++;
        if (pzeros > PREFIX_LIMIT_DEF) pvalid = 0;
      end else if (pzeros == 0) begin
        finish_element(0);
      end else begin
        suffix = 1; nbits = 0; acc = 0;
      end
      return;
    end
    acc = ((acc << 1) | b) & 64'h1_FFFF_FFFF;
    nbits++;
    if (nbits >= pzeros)
      finish_element(32'(((64'd1 << pzeros) - 1) + acc));
  endfunction

  function automatic dims_word_t cropped_dims();
    dims_word_t r;
    logic [31:0] sw, sh, ux, uy, pw, ph, fl;
    r = '0;
    if (!pvalid || !pdone || chroma > 3) return r;
    sw = (chroma == 1 || chroma == 2) ? 2 : 1;
    sh = (chroma == 1) ? 2 : 1;
    fl = 2 - frame_only;
    ux = (chroma == 0) ? 1 : sw;
    uy = ((chroma == 0) ? 1 : sh) * fl;
    pw = (wunits + 32'd1) * 32'd16 - (crop[0] + crop[1]) * ux;
    ph = fl * (hunits + 32'd1) * 32'd16 - (crop[2] + crop[3]) * uy;
    if (pw == 0 || ph == 0 || pw > lim_w || ph > lim_h) return r;
    r.ok = 1; r.width = pw[13:0]; r.height = ph[13:0];
    return r;
  endfunction

  function automatic void predict_byte(byte unsigned b, bit last);
    if (!hdr_seen) hdr_seen = 1;
    else if (zrun >= 2 && b == 3) zrun = 0;
    else begin
      for (int i = 7; i >= 0; i--) take_bit(b[i]);
      zrun = (b == 0) ? ((zrun < 3) ? zrun + 1 : 3) : 0;
    end
    if (last) begin
      expected_dims.push_back(cropped_dims());
      clear_parser();
    end
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    dims_word_t got, exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.dims_ok, out_ch.frame_width, out_ch.frame_height};
      if (expected_dims.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        exp_w = expected_dims.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_w, got);
        end
      end
    end
  end

  // The word stays on the bus after acceptance; the next call or drain replaces it.
  task automatic send_byte(byte unsigned b, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.nal_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b, last);
  endtask

  task automatic send_nal();
    foreach (nal[i]) send_byte(nal[i], i == nal.size() - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_dims.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic idx, logic [13:0] v);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MAX_WIDTH) lim_w = v; else lim_h = v;
  endtask

  function automatic void put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) sps_bits.push_back(v[i]);
  endfunction

  function automatic void put_ue(longint unsigned v);
    longint unsigned x;
    int len;
    x = v + 1;
    len = 0;
    while ((x >> len) > 1) len++;
    put_bits(0, len);
    put_bits(x, len + 1);
  endfunction

  function automatic void put_se(int v);
    put_ue(v > 0 ? 2 * v - 1 : -2 * v);
  endfunction

  // Packs the bit list into NAL bytes with header and optional emulation prevention.
  function automatic void pack_nal(bit add_epb);
    byte unsigned b;
    int z;
    nal = {};
    nal.push_back(8'h67);
    sps_bits.push_back(1);
    while (sps_bits.size() % 8 != 0) sps_bits.push_back(0);
    z = 0;
    for (int i = 0; i < sps_bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = sps_bits[i + k];
      if (add_epb && z >= 2 && b <= 3) begin nal.push_back(3); z = 0; end
      nal.push_back(b);
      z = (b == 0) ? z + 1 : 0;
    end
    sps_bits = {};
  endfunction

  // Builds an SPS from the given fields, with random values for the other elements.
  function automatic void build_sps(int unsigned prof, int unsigned chf, int unsigned poc,
                                    int unsigned wu, int unsigned hu, bit fo,
                                    bit crop_on, int unsigned cmax);
    int unsigned n, cl, sz;
    int d;
    sps_bits = {};
    put_bits(prof, 8);
    put_bits($urandom_range(255), 8);
    put_bits($urandom_range(255), 8);
    put_ue($urandom_range(31));
    if (is_high(prof)) begin
      put_ue(chf);
      if (chf == 3) put_bits($urandom_range(1), 1);
      put_ue($urandom_range(6));
      put_ue($urandom_range(6));
      put_bits($urandom_range(1), 1);
      n = $urandom_range(1);
      put_bits(n, 1);
      if (n) begin
        cl = (chf == 3) ? 12 : 8;
        for (int l = 0; l < cl; l++) begin
          n = ($urandom_range(3) == 0);
          put_bits(n, 1);
          if (n) begin
            sz = (l < 6) ? 16 : 64;
            for (int e = 0; e < sz; e++) begin
              d = $urandom_range(16) - 8;
              if ($urandom_range(40) == 0) d = ($urandom_range(1)) ? 127 : -128;
              put_se(d);
              if ($urandom_range(30) == 0) break;
            end
          end
        end
      end
    end
    put_ue($urandom_range(12));
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(12));
    else if (poc == 1) begin
      put_bits($urandom_range(1), 1);
      put_se($urandom_range(40) - 20);
      put_se($urandom_range(40) - 20);
      cl = $urandom_range(4);
      put_ue(cl);
      for (int i = 0; i < cl; i++) put_se($urandom_range(10) - 5);
    end
    put_ue($urandom_range(16));
    put_bits($urandom_range(1), 1);
    put_ue(wu);
    put_ue(hu);
    put_bits(fo, 1);
    if (!fo) put_bits($urandom_range(1), 1);
    put_bits($urandom_range(1), 1);
    put_bits(crop_on, 1);
    if (crop_on) for (int i = 0; i < 4; i++) put_ue($urandom_range(cmax));
  endfunction

  function automatic int unsigned pick_profile();
    int unsigned hp[12] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134};
    if ($urandom_range(1)) return hp[$urandom_range(11)];
    return $urandom_range(255);
  endfunction

  task automatic test_directed();
    build_sps(66, 1, 0, 119, 67, 1, 0, 0); pack_nal(1); send_nal();
    build_sps(100, 0, 1, 0, 0, 1, 1, 3); pack_nal(1); send_nal();
    build_sps(244, 3, 2, 10, 10, 0, 1, 7); pack_nal(1); send_nal();
    build_sps(122, 2, 0, 255, 143, 1, 0, 0); pack_nal(1); send_nal();
    build_sps(100, 4, 0, 10, 10, 1, 0, 0); pack_nal(1); send_nal();
    build_sps(77, 1, 0, 32'hFFFF_FFFE, 0, 1, 0, 0); pack_nal(1); send_nal();
    build_sps(77, 1, 0, 1, 1, 1, 1, 40); pack_nal(1); send_nal();
    build_sps(66, 1, 0, 20, 20, 1, 0, 0); pack_nal(1);
    nal = nal[0:nal.size() - 3]; send_nal();
    send_byte(8'h67, 1);
    nal = {8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_nal();
    nal = {8'h67, 8'h42, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h03, 8'hFF};
    send_nal();
    send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'hAA, 0);
    send_byte(8'h55, 1);
    drain();
  endtask

  task automatic test_random(int unsigned nal_count);
    int unsigned m;
    for (int k = 0; k < nal_count; k++) begin
      m = $urandom_range(9);
      if (m < 7) begin
        build_sps(pick_profile(), $urandom_range(4), $urandom_range(3),
                  $urandom_range(130), $urandom_range(80), $urandom_range(1),
                  $urandom_range(1), $urandom_range(12));
        pack_nal(m != 0);
        if ($urandom_range(12) == 0) nal = nal[0:$urandom_range(nal.size() - 1)];
      end else begin
        nal = {};
        repeat ($urandom_range(1, 12))
          nal.push_back(($urandom_range(2) == 0) ? $urandom_range(3) : $urandom_range(255));
      end
      send_nal();
    end
    drain();
  endtask

  task automatic test_limits();
    write_limit(CFG_MAX_WIDTH, 14'd8192);
    write_limit(CFG_MAX_HEIGHT, 14'd8192);
    test_random(10);
    write_limit(CFG_MAX_WIDTH, 14'd1);
    write_limit(CFG_MAX_HEIGHT, 14'd1);
    build_sps(66, 1, 0, 0, 0, 1, 1, 0); pack_nal(1); send_nal();
    test_random(6);
    write_limit(CFG_MAX_WIDTH, 14'd0);
    write_limit(CFG_MAX_HEIGHT, 14'd16383);
    test_random(6);
    write_limit(CFG_MAX_WIDTH, 14'd640);
    write_limit(CFG_MAX_HEIGHT, 14'd480);
    test_random(10);
  endtask

  initial begin
    mismatches = 0;
    send_idle_pct = 33;
    recv_idle_pct = 50;
    lim_w = 4096;
    lim_h = 2304;
    clear_parser();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.nal_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MAX_WIDTH;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    write_limit(CFG_MAX_WIDTH, 14'd4096);
    write_limit(CFG_MAX_HEIGHT, 14'd2304);
    test_random(37);
    send_idle_pct = 50;
    recv_idle_pct = 33;
    test_random(37);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(37);
    drain();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
